@@ sv/gqi_pkg.sv @@
package gqi_pkg;

    localparam int RATE_W        = 24;
    localparam int ATT_W         = 32;
    localparam int STEP_W        = 24;
    localparam int SUM_W         = 48;
    localparam int RATE_FRAC_DEF = 16;
    localparam int QUAT_FRAC_DEF = 30;
    localparam int TAYLOR_TERMS  = 10;

    localparam logic [STEP_W-1:0] STEP_RESET = 24'd33554;
    localparam logic [34:0] TWO_PI_Q32  = 35'd26986075409;
    localparam logic [34:0] HALF_PI_Q32 = 35'd6746518852;
    localparam logic [34:0] PI_Q32      = 35'd13493037704;
    localparam logic [34:0] PI3_2_Q32   = 35'd20239556556;

    typedef logic [8:0]  tdiv_t;
    typedef logic [33:0] recip_t;

    localparam tdiv_t SIN_DIV [TAYLOR_TERMS] = '{
        9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342, 9'd420};
    localparam tdiv_t COS_DIV [TAYLOR_TERMS] = '{
        9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306, 9'd380};

    // floor(2^34 / divisor)
    localparam recip_t SIN_RECIP [TAYLOR_TERMS] = '{
        34'((64'd1 << 34) / 64'd6),   34'((64'd1 << 34) / 64'd20),
        34'((64'd1 << 34) / 64'd42),  34'((64'd1 << 34) / 64'd72),
        34'((64'd1 << 34) / 64'd110), 34'((64'd1 << 34) / 64'd156),
        34'((64'd1 << 34) / 64'd210), 34'((64'd1 << 34) / 64'd272),
        34'((64'd1 << 34) / 64'd342), 34'((64'd1 << 34) / 64'd420)};
    localparam recip_t COS_RECIP [TAYLOR_TERMS] = '{
        34'((64'd1 << 34) / 64'd2),   34'((64'd1 << 34) / 64'd12),
        34'((64'd1 << 34) / 64'd30),  34'((64'd1 << 34) / 64'd56),
        34'((64'd1 << 34) / 64'd90),  34'((64'd1 << 34) / 64'd132),
        34'((64'd1 << 34) / 64'd182), 34'((64'd1 << 34) / 64'd240),
        34'((64'd1 << 34) / 64'd306), 34'((64'd1 << 34) / 64'd380)};

    typedef struct packed {
        logic signed [RATE_W-1:0] rx;
        logic signed [RATE_W-1:0] ry;
        logic signed [RATE_W-1:0] rz;
        logic [SUM_W-1:0]         sum;
        logic                     zero;
    } gqi_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // sign of term k of Hamilton product component j
    function automatic logic ham_neg(input logic [1:0] j, input logic [1:0] k);
        logic r;
        unique case (j)
            2'd0:    r = (k != 2'd0);
            2'd1:    r = (k == 2'd3);
            2'd2:    r = (k == 2'd1);
            default: r = (k == 2'd2);
        endcase
        return r;
    endfunction

endpackage

@@ sv/gqi_if.sv @@
interface gqi_rate_if import gqi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;

    modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
    modport sink   (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

interface gqi_att_if import gqi_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ATT_W-1:0] att_w;
    logic signed [ATT_W-1:0] att_x;
    logic signed [ATT_W-1:0] att_y;
    logic signed [ATT_W-1:0] att_z;

    modport source (output valid, output att_w, output att_x, output att_y, output att_z,
                    input ready);
    modport sink   (input valid, input att_w, input att_x, input att_y, input att_z,
                    output ready);
endinterface

@@ sv/gqi_front.sv @@
module gqi_front import gqi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    gqi_rate_if.sink   sample,
    input  q_stat_t    q_stat,
    output logic       q_push,
    output gqi_item_t  q_item
);

    logic                     busy_reg, busy_next;
    logic [1:0]               cnt_reg, cnt_next;
    logic signed [RATE_W-1:0] rx_reg, ry_reg, rz_reg;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic signed [RATE_W-1:0] sel;
    logic signed [SUM_W-1:0]  sq;
    logic                     take;

    assign sample.ready = !busy_reg;
    assign take         = sample.valid && !busy_reg;

    always_comb
    begin
        unique case (cnt_reg)
            2'd0:    sel = rx_reg;
            2'd1:    sel = ry_reg;
            default: sel = rz_reg;
        endcase
    end

    assign sq = sel * sel;

    assign q_push      = busy_reg && (cnt_reg == 2'd3) && !q_stat.full;
    assign q_item.rx   = rx_reg;
    assign q_item.ry   = ry_reg;
    assign q_item.rz   = rz_reg;
    assign q_item.sum  = sum_reg;
    assign q_item.zero = (sum_reg == '0);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        if (take)
        begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
            sum_next  = '0;
        end
        else if (busy_reg && cnt_reg != 2'd3)
        begin
            sum_next = sum_reg + SUM_W'(sq);
            cnt_next = cnt_reg + 2'd1;
        end
        else if (q_push)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (take)
        begin
            rx_reg <= sample.rate_x;
            ry_reg <= sample.rate_y;
            rz_reg <= sample.rate_z;
        end
    end

endmodule

@@ sv/gqi_queue.sv @@
module gqi_queue import gqi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  gqi_item_t push_data,
    input  logic      pop,
    output gqi_item_t pop_data,
    output q_stat_t   stat
);

    gqi_item_t  mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.empty = (cnt_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wp_reg <= !wp_reg;
            if (do_pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wp_reg] <= push_data;
    end

endmodule

@@ sv/gqi_div.sv @@
module gqi_div #(
    parameter int DW = 62,
    parameter int VW = 31,
    parameter int QW = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [QW-1:0] quotient
);

    localparam int CW = $clog2(QW + 1);

    logic          busy_reg, done_reg;
    logic [CW-1:0] cnt_reg;
    logic [VW-1:0] rem_reg, div_reg;
    logic [QW-1:0] quo_reg;
    logic [VW:0]   trial;
    logic          fits;

    assign trial    = {rem_reg, quo_reg[QW-1]};
    assign fits     = (trial >= {1'b0, div_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= VW'(dividend[DW-1:QW]);
            quo_reg <= dividend[QW-1:0];
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? VW'(trial - {1'b0, div_reg}) : trial[VW-1:0];
            quo_reg <= {quo_reg[QW-2:0], fits};
        end
    end

endmodule

@@ sv/gqi_back.sv @@
module gqi_back import gqi_pkg::*; #(
    parameter int RATE_FRAC_BITS = RATE_FRAC_DEF,
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [STEP_W-1:0] step_time,
    input  q_stat_t           q_stat,
    input  gqi_item_t         q_data,
    output logic              q_pop,
    gqi_att_if.source         result
);

    localparam int TH_W      = 31 + STEP_W - RATE_FRAC_BITS;
    localparam int MR_W      = ((TH_W > 35) ? TH_W : 35) + 1;
    localparam int MOD_STEPS = (TH_W > 34) ? TH_W - 33 : 1;

    localparam logic signed [ATT_W-1:0] ONE_Q = ATT_W'(64'sd1 <<< QUAT_FRAC_BITS);
    localparam logic signed [35:0] SAT_HI = (36'sd1 <<< (QUAT_FRAC_BITS + 1)) - 36'sd1;
    localparam logic signed [35:0] SAT_LO = -(36'sd1 <<< (QUAT_FRAC_BITS + 1));
    localparam logic signed [65:0] RND    = 66'sd536870912;
    localparam logic signed [32:0] TRIG_ONE = 33'sd1073741824;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_SQRT  = 16'h0002,
        S_THETA = 16'h0004,
        S_MOD   = 16'h0008,
        S_QUAD  = 16'h0010,
        S_X2    = 16'h0020,
        S_TMUL  = 16'h0040,
        S_TREC  = 16'h0080,
        S_TCRT  = 16'h0100,
        S_TFIN  = 16'h0200,
        S_MAP   = 16'h0400,
        S_VMUL  = 16'h0800,
        S_VGO   = 16'h1000,
        S_VDIV  = 16'h2000,
        S_PROD  = 16'h4000,
        S_DONE  = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    logic [5:0]               cnt_reg, cnt_next;
    logic                     sel_reg, sel_next;
    logic [1:0]               vi_reg, vi_next;
    logic                     ov_reg, ov_next;

    logic signed [RATE_W-1:0] rx_reg [3];
    logic signed [ATT_W-1:0]  att_reg [4];
    logic signed [ATT_W-1:0]  n_reg [4];
    logic signed [ATT_W-1:0]  out_reg [4];
    logic signed [32:0]       d_reg [4];
    logic [61:0]              sqn_reg;
    logic [63:0]              res_reg;
    logic [MR_W-1:0]          th_reg;
    logic [1:0]               quad_reg;
    logic [30:0]              x_reg;
    logic [31:0]              x2_reg;
    logic [32:0]              ts_reg, tc_reg, tdv_reg;
    logic signed [34:0]       sv_reg, cv_reg;
    logic [31:0]              q0_reg;
    logic [33:0]              qc_reg;
    logic signed [32:0]       s_reg;
    logic [61:0]              vp_reg;
    logic signed [65:0]       acc_reg, prod_reg;

    logic signed [34:0]       ma, mb;
    logic signed [69:0]       mp;
    logic [69:0]              mpu;

    logic [63:0]              sq_bit, sq_trial;
    logic [MR_W-1:0]          tw;
    logic [34:0]              rr, rsub;
    logic [1:0]               quad;
    logic [3:0]               tk;
    logic [8:0]               tdiv;
    logic [33:0]              trem;
    logic [32:0]              tq;
    logic [RATE_W-1:0]        rmag;
    logic [32:0]              smag;
    logic                     div_done;
    logic [31:0]              div_q;
    logic [3:0]               ptag;
    logic signed [65:0]       psum;
    logic signed [35:0]       psh;
    logic signed [ATT_W-1:0]  psat;
    logic                     load_out;

    assign tk      = cnt_reg[3:0];
    assign tdiv    = sel_reg ? COS_DIV[tk] : SIN_DIV[tk];
    assign rmag    = rx_reg[vi_reg][RATE_W-1] ? RATE_W'(-rx_reg[vi_reg])
                                              : RATE_W'(rx_reg[vi_reg]);
    assign smag    = s_reg[32] ? 33'(-s_reg) : 33'(s_reg);
    assign sq_bit  = 64'd1 << {cnt_reg[4:0], 1'b0};
    assign sq_trial = res_reg + sq_bit;
    assign tw      = MR_W'(TWO_PI_Q32) << cnt_reg;
    assign rr      = th_reg[34:0];
    assign trem    = {1'b0, tdv_reg} - qc_reg;
    assign tq      = {1'b0, q0_reg} + 33'(trem >= {25'd0, tdiv});
    assign ptag    = 4'(cnt_reg - 6'd1);

    always_comb
    begin
        priority if (rr >= PI3_2_Q32)
        begin
            quad = 2'd3;
            rsub = rr - PI3_2_Q32;
        end
        else if (rr >= PI_Q32)
        begin
            quad = 2'd2;
            rsub = rr - PI_Q32;
        end
        else if (rr >= HALF_PI_Q32)
        begin
            quad = 2'd1;
            rsub = rr - HALF_PI_Q32;
        end
        else
        begin
            quad = 2'd0;
            rsub = rr;
        end
    end

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            S_THETA:
            begin
                ma = {4'd0, res_reg[30:0]};
                mb = {11'd0, step_time};
            end
            S_X2:
            begin
                ma = {4'd0, x_reg};
                mb = {4'd0, x_reg};
            end
            S_TMUL:
            begin
                ma = {2'd0, (sel_reg ? tc_reg : ts_reg)};
                mb = {3'd0, x2_reg};
            end
            S_TREC:
            begin
                ma = {2'd0, tdv_reg};
                mb = {1'b0, (sel_reg ? COS_RECIP[tk] : SIN_RECIP[tk])};
            end
            S_TCRT:
            begin
                ma = {3'd0, q0_reg};
                mb = {26'd0, tdiv};
            end
            S_VMUL:
            begin
                ma = {4'd0, rmag, 7'd0};
                mb = {2'd0, smag};
            end
            S_PROD:
            begin
                ma = {{3{att_reg[cnt_reg[1:0]][ATT_W-1]}}, att_reg[cnt_reg[1:0]]};
                mb = {{2{d_reg[cnt_reg[3:2] ^ cnt_reg[1:0]][32]}},
                      d_reg[cnt_reg[3:2] ^ cnt_reg[1:0]]};
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign mp  = ma * mb;
    assign mpu = mp;

    always_comb
    begin
        psum = acc_reg + (ham_neg(ptag[3:2], ptag[1:0]) ? -prod_reg : prod_reg);
        psh  = psum[65:30];
        priority if (psh > SAT_HI)
            psat = ATT_W'(SAT_HI);
        else if (psh < SAT_LO)
            psat = ATT_W'(SAT_LO);
        else
            psat = psh[ATT_W-1:0];
    end

    gqi_div #(.DW(62), .VW(31), .QW(32)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_VGO),
        .dividend (vp_reg),
        .divisor  (res_reg[30:0]),
        .done     (div_done),
        .quotient (div_q)
    );

    assign q_pop    = (state_reg == S_IDLE) && !q_stat.empty;
    assign load_out = (state_reg == S_DONE) && (!ov_reg || result.ready);

    assign result.valid = ov_reg;
    assign result.att_w = out_reg[0];
    assign result.att_x = out_reg[1];
    assign result.att_y = out_reg[2];
    assign result.att_z = out_reg[3];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        vi_next    = vi_reg;
        ov_next    = ov_reg;
        if (ov_reg && result.ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    cnt_next   = q_data.zero ? 6'd0 : 6'd31;
                    state_next = q_data.zero ? S_PROD : S_SQRT;
                end
            end
            S_SQRT:
            begin
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                    state_next = S_THETA;
            end
            S_THETA:
            begin
                cnt_next   = 6'(MOD_STEPS - 1);
                state_next = S_MOD;
            end
            S_MOD:
            begin
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                    state_next = S_QUAD;
            end
            S_QUAD:  state_next = S_X2;
            S_X2:
            begin
                cnt_next   = 6'd0;
                sel_next   = 1'b0;
                state_next = S_TMUL;
            end
            S_TMUL:  state_next = S_TREC;
            S_TREC:  state_next = S_TCRT;
            S_TCRT:  state_next = S_TFIN;
            S_TFIN:
            begin
                sel_next   = !sel_reg;
                state_next = S_TMUL;
                if (sel_reg)
                begin
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'(TAYLOR_TERMS - 1))
                        state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                vi_next    = 2'd0;
                state_next = S_VMUL;
            end
            S_VMUL:  state_next = S_VGO;
            S_VGO:   state_next = S_VDIV;
            S_VDIV:
            begin
                if (div_done)
                begin
                    vi_next = vi_reg + 2'd1;
                    if (vi_reg == 2'd2)
                    begin
                        cnt_next   = 6'd0;
                        state_next = S_PROD;
                    end
                    else
                    begin
                        state_next = S_VMUL;
                    end
                end
            end
            S_PROD:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd16)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            sel_reg    <= 1'b0;
            vi_reg     <= 2'd0;
            ov_reg     <= 1'b0;
            att_reg[0] <= ONE_Q;
            att_reg[1] <= '0;
            att_reg[2] <= '0;
            att_reg[3] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
            vi_reg    <= vi_next;
            ov_reg    <= ov_next;
            if (load_out)
                att_reg <= n_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_reg <= n_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                rx_reg[0] <= q_data.rx;
                rx_reg[1] <= q_data.ry;
                rx_reg[2] <= q_data.rz;
                sqn_reg   <= {q_data.sum[47:0], 14'd0};
                res_reg   <= '0;
                d_reg[0]  <= TRIG_ONE;
                d_reg[1]  <= '0;
                d_reg[2]  <= '0;
                d_reg[3]  <= '0;
                acc_reg   <= RND;
            end
            S_SQRT:
            begin
                if ({2'd0, sqn_reg} >= sq_trial)
                begin
                    sqn_reg <= 62'({2'd0, sqn_reg} - sq_trial);
                    res_reg <= (res_reg >> 1) + sq_bit;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
            end
            S_THETA: th_reg <= MR_W'(mpu >> RATE_FRAC_BITS);
            S_MOD:
            begin
                if (th_reg >= tw)
                    th_reg <= th_reg - tw;
            end
            S_QUAD:
            begin
                quad_reg <= quad;
                x_reg    <= rsub[32:2];
            end
            S_X2:
            begin
                x2_reg <= mpu[61:30];
                ts_reg <= {2'd0, x_reg};
                tc_reg <= 33'd1073741824;
                sv_reg <= {4'd0, x_reg};
                cv_reg <= 35'sd1073741824;
            end
            S_TMUL:  tdv_reg <= mpu[62:30];
            S_TREC:  q0_reg  <= mpu[65:34];
            S_TCRT:  qc_reg  <= mpu[33:0];
            S_TFIN:
            begin
                if (sel_reg)
                begin
                    tc_reg <= tq;
                    cv_reg <= tk[0] ? cv_reg + {2'd0, tq} : cv_reg - {2'd0, tq};
                end
                else
                begin
                    ts_reg <= tq;
                    sv_reg <= tk[0] ? sv_reg + {2'd0, tq} : sv_reg - {2'd0, tq};
                end
            end
            S_MAP:
            begin
                unique case (quad_reg)
                    2'd0:
                    begin
                        s_reg    <= 33'(sv_reg);
                        d_reg[0] <= 33'(cv_reg);
                    end
                    2'd1:
                    begin
                        s_reg    <= 33'(cv_reg);
                        d_reg[0] <= 33'(-sv_reg);
                    end
                    2'd2:
                    begin
                        s_reg    <= 33'(-sv_reg);
                        d_reg[0] <= 33'(-cv_reg);
                    end
                    default:
                    begin
                        s_reg    <= 33'(-cv_reg);
                        d_reg[0] <= 33'(sv_reg);
                    end
                endcase
            end
            S_VMUL:  vp_reg <= mpu[61:0];
            S_VDIV:
            begin
                if (div_done)
                begin
                    if (rx_reg[vi_reg][RATE_W-1] != s_reg[32])
                        d_reg[vi_reg + 2'd1] <= -$signed({1'b0, div_q});
                    else
                        d_reg[vi_reg + 2'd1] <= $signed({1'b0, div_q});
                end
            end
            S_PROD:
            begin
                prod_reg <= mp[65:0];
                if (cnt_reg != 6'd0)
                begin
                    if (ptag[1:0] == 2'd3)
                    begin
                        n_reg[ptag[3:2]] <= psat;
                        acc_reg          <= RND;
                    end
                    else
                    begin
                        acc_reg <= psum;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ sv/gyro_quaternion_integrator_top.sv @@
// Flow: the front squares and sums the three rates; the back sequencer then takes the square
// root, reduces the angle, runs the Taylor series, does three divides and the Hamilton product;
// when all rates are zero, it goes straight to the product.
// The back sequencer handles one sample at a time with its shared multiplier and divider,
// which sets the throughput; a two-entry queue lets the front take samples meanwhile.
// Reset (rst_n low, async): attitude to identity, step_time to 33554, queue and result empty.
module gyro_quaternion_integrator_top import gqi_pkg::*; #(
    parameter int RATE_FRAC_BITS = RATE_FRAC_DEF,
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [STEP_W-1:0] cfg_wdata,
    gqi_rate_if.sink          sample,
    gqi_att_if.source         result
);

    logic [STEP_W-1:0] step_time_reg;
    logic              q_push, q_pop;
    gqi_item_t         q_in, q_out;
    q_stat_t           q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_time_reg <= STEP_RESET;
        else if (cfg_we)
            step_time_reg <= cfg_wdata;
    end

    gqi_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .q_stat (q_stat),
        .q_push (q_push),
        .q_item (q_in)
    );

    gqi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    gqi_back #(
        .RATE_FRAC_BITS (RATE_FRAC_BITS),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_time (step_time_reg),
        .q_stat    (q_stat),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .result    (result)
    );

endmodule
